// File: hw/rtl/smpm_pkg.sv
// Shared types, constants and codes for the stripe/mirror/partition mapper.
`default_nettype none

package smpm_pkg;

  // Geometry
  localparam int BLOCK_SIZE  = 4096;
  localparam int MEMBERS     = 8;
  localparam int MAX_RESULTS = 64;

  // Field widths
  localparam int OFF_W      = 40;
  localparam int LEN_W      = 18;
  localparam int MOFF_W     = 41;
  localparam int MEMBER_W   = 3;
  localparam int CNT_W      = 4;
  localparam int MASK_W     = 8;
  localparam int STAT_W     = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;

  // Derived widths
  localparam int BLK_W  = $clog2(BLOCK_SIZE);
  localparam int DIV_W  = OFF_W - BLK_W;
  localparam int ROW_W  = MOFF_W - BLK_W;
  localparam int SEG_W  = $clog2(MAX_RESULTS);
  localparam int STEP_W = $clog2(DIV_W + 1);

  // Mode register bits
  localparam int MODE_MIRROR_BIT = 0;
  localparam int MODE_STRIPE_BIT = 1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_MEMBER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_STRIPE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE         = 3'd0,
    CFG_MEMBER_COUNT = 3'd1,
    CFG_VALID_MASK   = 3'd2,
    CFG_TOTAL_SIZE   = 3'd3,
    CFG_BASE_OFFSET  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PLAN_STATUS,
    PLAN_SINGLE,
    PLAN_MIRROR,
    PLAN_STRIPE
  } plan_e;

  typedef struct packed {
    logic             is_write;
    logic [OFF_W-1:0] request_offset;
    logic [LEN_W-1:0] request_length;
  } req_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] member_index;
    logic [MOFF_W-1:0]   member_offset;
    logic [LEN_W-1:0]    segment_length;
    logic [STAT_W-1:0]   status;
    logic                last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch the request beat
    logic classify;  // register the plan and initialise the walk
    logic emit;      // load the output register with the current segment
    logic step;      // advance the walk position
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    plan_e plan_next;
    logic  div_done;
    logic  cand_valid;
    logic  cand_last;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/smpm_div.sv
// Bit-serial divider: block number by member count, one quotient bit a cycle.
`default_nettype none

module smpm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [smpm_pkg::DIV_W-1:0]    dividend_i,
  input  logic [smpm_pkg::CNT_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [smpm_pkg::DIV_W-1:0]    quot_o,
  output logic [smpm_pkg::MEMBER_W-1:0] rem_o
);
  import smpm_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [STEP_W-1:0]   step_q;
  logic [DIV_W-1:0]    dq_q;
  logic [MEMBER_W-1:0] rem_q;
  logic [CNT_W-1:0]    trial;
  logic                ge;

  // Partial remainder stays below the divisor, so it fits the member width
  assign trial = {rem_q, dq_q[DIV_W-1]};
  assign ge    = (trial >= divisor_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? MEMBER_W'(trial - divisor_i) : MEMBER_W'(trial);
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// File: hw/rtl/smpm_dpath.sv
// Datapath: configuration registers, request checks, walk position and result register.
`default_nettype none

module smpm_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smpm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  smpm_pkg::req_t                  req_i,
  input  smpm_pkg::cmd_t                  cmd_i,
  output smpm_pkg::sts_t                  sts_o,
  output smpm_pkg::res_t                  res_o
);
  import smpm_pkg::*;

  // Configuration
  logic [MODE_W-1:0]  mode_q;
  logic [CNT_W-1:0]   count_q;
  logic [MASK_W-1:0]  valid_q;
  logic [OFF_W-1:0]   size_q;
  logic [OFF_W-1:0]   base_q;

  // Request and walk
  req_t                req_q;
  plan_e               plan_q;
  logic [STAT_W-1:0]   stat_q;
  logic [LEN_W-1:0]    len_q;
  logic [MEMBER_W-1:0] mem_q;
  logic [ROW_W-1:0]    row_q;
  logic [BLK_W-1:0]    within_q;
  logic [SEG_W-1:0]    seg_q;
  logic [MASK_W-1:0]   vmask_q;
  logic [MOFF_W-1:0]   sum_q;
  res_t                out_q;

  // Combinational
  logic [CNT_W-1:0]    cnt;
  logic [MEMBER_W-1:0] cnt_m1;
  logic [MASK_W-1:0]   use_mask;
  logic [MASK_W-1:0]   vin;
  logic [MEMBER_W-1:0] first_m;
  logic                past_end;
  logic [OFF_W-1:0]    room;
  logic [LEN_W-1:0]    n_clip;
  logic                clip_empty;
  plan_e               plan_d;
  logic [STAT_W-1:0]   stat_d;
  logic [LEN_W-1:0]    len_d;
  logic [MEMBER_W-1:0] mem_d;
  logic [BLK_W:0]      blk_room;
  logic [LEN_W-1:0]    chunk;
  logic [MASK_W-1:0]   vhi;
  res_t                cand;
  logic                cand_valid;
  logic                cand_last;
  logic                div_done;
  logic [DIV_W-1:0]    div_quot;
  logic [MEMBER_W-1:0] div_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      count_q <= CNT_W'(1);
      valid_q <= '1;
      size_q  <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:         mode_q  <= cfg_wdata_i[MODE_W-1:0];
        CFG_MEMBER_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_VALID_MASK:   valid_q <= cfg_wdata_i[MASK_W-1:0];
        CFG_TOTAL_SIZE:   size_q  <= cfg_wdata_i[OFF_W-1:0];
        CFG_BASE_OFFSET:  base_q  <= cfg_wdata_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Members in use: zero counts as one, clamp at the member limit
  always_comb begin
    if (count_q == '0) begin
      cnt = CNT_W'(1);
    end else if (count_q > CNT_W'(MEMBERS)) begin
      cnt = CNT_W'(MEMBERS);
    end else begin
      cnt = count_q;
    end
  end
  assign cnt_m1 = MEMBER_W'(cnt - CNT_W'(1));

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      use_mask[i] = (CNT_W'(i) < cnt);
    end
  end
  assign vin = valid_q & use_mask;

  always_comb begin
    first_m = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (vin[i]) begin
        first_m = MEMBER_W'(i);
      end
    end
  end

  // Clip against the device size
  assign past_end   = (req_q.request_offset >= size_q);
  assign room       = size_q - req_q.request_offset;
  assign n_clip     = (room < OFF_W'(req_q.request_length)) ? room[LEN_W-1:0]
                                                            : req_q.request_length;
  assign clip_empty = past_end || (n_clip == '0);

  always_comb begin
    plan_d = PLAN_STATUS;
    stat_d = ST_EMPTY;
    len_d  = n_clip;
    mem_d  = '0;
    if (mode_q[MODE_STRIPE_BIT]) begin
      if (req_q.is_write) begin
        if (req_q.request_length != '0) begin
          plan_d = PLAN_STRIPE;
          len_d  = req_q.request_length;
        end
      end else if (!clip_empty) begin
        plan_d = PLAN_STRIPE;
      end
    end else if (mode_q[MODE_MIRROR_BIT]) begin
      if (vin == '0) begin
        stat_d = ST_NO_MEMBER;
      end else if (!req_q.is_write) begin
        if (!clip_empty) begin
          plan_d = PLAN_SINGLE;
          mem_d  = first_m;
        end
      end else if (req_q.request_length != '0) begin
        plan_d = PLAN_MIRROR;
        len_d  = req_q.request_length;
      end
    end else if (!clip_empty) begin
      plan_d = PLAN_SINGLE;
    end
  end

  smpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.classify && (plan_d == PLAN_STRIPE)),
    .dividend_i (req_q.request_offset[OFF_W-1:BLK_W]),
    .divisor_i  (cnt),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Segment at the current walk position
  assign blk_room = (BLK_W+1)'(BLOCK_SIZE) - {1'b0, within_q};
  assign chunk    = (len_q < LEN_W'(blk_room)) ? len_q : LEN_W'(blk_room);
  assign vhi      = vmask_q >> mem_q;

  always_comb begin
    cand       = '0;
    cand.last  = 1'b1;
    cand_valid = 1'b1;
    cand_last  = 1'b1;
    case (plan_q)
      PLAN_STATUS: begin
        cand.status = stat_q;
      end
      PLAN_SINGLE: begin
        cand.member_index   = mem_q;
        cand.member_offset  = sum_q;
        cand.segment_length = len_q;
        cand.status         = ST_OK;
      end
      PLAN_MIRROR: begin
        cand_valid          = vmask_q[mem_q];
        cand_last           = ((vhi >> 1) == '0);
        cand.member_index   = mem_q;
        cand.member_offset  = sum_q;
        cand.segment_length = len_q;
        cand.status         = ST_OK;
        cand.last           = cand_last;
      end
      default: begin
        cand.member_index  = mem_q;
        cand.member_offset = {row_q, within_q};
        if (req_q.is_write && !valid_q[mem_q]) begin
          cand.status = ST_BAD_STRIPE;
        end else begin
          cand_last           = (len_q <= LEN_W'(blk_room)) ||
                                (seg_q == SEG_W'(MAX_RESULTS - 1));
          cand.segment_length = chunk;
          cand.status         = ST_OK;
          cand.last           = cand_last;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.emit) begin
      out_q <= cand;
    end
    if (cmd_i.classify) begin
      plan_q   <= plan_d;
      stat_q   <= stat_d;
      len_q    <= len_d;
      mem_q    <= mem_d;
      vmask_q  <= vin;
      sum_q    <= MOFF_W'(req_q.request_offset) + MOFF_W'(base_q);
      within_q <= req_q.request_offset[BLK_W-1:0];
      seg_q    <= '0;
    end else if (div_done) begin
      mem_q <= div_rem;
      row_q <= ROW_W'(div_quot);
    end else if (cmd_i.step) begin
      case (plan_q)
        PLAN_MIRROR: begin
          mem_q <= mem_q + MEMBER_W'(1);
        end
        PLAN_STRIPE: begin
          len_q    <= len_q - chunk;
          within_q <= '0;
          seg_q    <= seg_q + SEG_W'(1);
          if (mem_q == cnt_m1) begin
            mem_q <= '0;
            row_q <= row_q + ROW_W'(1);
          end else begin
            mem_q <= mem_q + MEMBER_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign sts_o.plan_next  = plan_d;
  assign sts_o.div_done   = div_done;
  assign sts_o.cand_valid = cand_valid;
  assign sts_o.cand_last  = cand_last;
  assign res_o            = out_q;

endmodule

`default_nettype wire

// File: hw/rtl/smpm_ctrl.sv
// Controller: sequences request intake, classification, division and the segment walk.
`default_nettype none

module smpm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  smpm_pkg::sts_t sts_i,
  output smpm_pkg::cmd_t cmd_o
);
  import smpm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV,
    ST_WALK
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.classify = (state_q == ST_CLASSIFY);
    if (state_q == ST_WALK && slot_free) begin
      cmd_o.emit = sts_i.cand_valid;
      cmd_o.step = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CLASSIFY;
          end
        end
        ST_CLASSIFY: begin
          state_q <= (sts_i.plan_next == PLAN_STRIPE) ? ST_DIV : ST_WALK;
        end
        ST_DIV: begin
          if (sts_i.div_done) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cmd_o.emit && sts_i.cand_last) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/stripe_mirror_partition_mapper.sv
// Top level of the stripe/mirror/partition address mapper.
`default_nettype none

// Maps one virtual-device request beat (read/write, byte offset, length) onto
// a run of member segment beats. Partition mode clips to the device size and
// adds the base offset on member 0; mirror reads go to the first valid member,
// mirror writes to every valid member in use (unclipped); interleave deals the
// request out in 4 KiB blocks round-robin over the members, clipping reads to
// the device size and stopping a write with an error beat when it reaches an
// invalid member. Empty requests, clipped requests that start beyond the end
// and memberless mirror requests give one status beat. Timing: one request at
// a time. A request beat is taken, then classified; interleave requests then
// pass through the bit-serial divider (28 quotient bits, then row and member
// are handed to the walk); after that the walk produces one segment per cycle
// unless the output side stalls (mirror writes step through each member up to
// the highest valid one and emit only for valid ones). The next request beat
// is taken as soon as the last segment has been loaded into the output
// register, while it may still be waiting to be taken. Configuration must
// only be written while idle.
module stripe_mirror_partition_mapper (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [smpm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  smpm_pkg::req_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output smpm_pkg::res_t                  out_data_o
);
  import smpm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing: intake, classify, divide, walk
  smpm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, configuration and the output register
  smpm_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (out_data_o)
  );

`ifndef SYNTHESIS
  // An accepted request closes the input until its last segment is in the output register
  a_intake_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again straight after a request beat");

  // Every error or status beat ends its request
  a_status_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.last)
    else $error("status beat without last");

  // Status beats carry no bytes
  a_status_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.segment_length == '0)
    else $error("status beat with a non-zero length");
`endif

endmodule

`default_nettype wire
